FILE: hdl/rpmt_pkg.sv
// Package for the range product segment tree.
// Types, constants and the sequencer state enum; no dependencies.
package rpmt_pkg;

  localparam int unsigned DEF_LEAVES = 1024;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned VAL_W      = 30;
  localparam logic [VAL_W-1:0] PRODUCT_MOD = 30'd1000000007;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_UPD_RD,
    ST_UPD_WAIT,
    ST_UPD_MUL,
    ST_Q_STEP,
    ST_Q_WAIT,
    ST_Q_MUL,
    ST_OUT
  } state_t;

endpackage

FILE: hdl/range_product_mod_tree_core.sv
// Range product segment tree: top level with node memory and sequencer.
// Depends on rpmt_pkg and rpmt_modmul.
// Reset starts a clearing pass that writes 1 to every node; no item is
// accepted meanwhile.
// Update: walks log2(LEAVES) tree levels, each set by reads of both children
// and the bit-serial multiplier. Query: a memory read and a multiply per
// visited node, up to 2*log2(LEAVES) nodes, then the output.
module range_product_mod_tree_core
  import rpmt_pkg::*;
#(
  parameter int unsigned LEAVES = DEF_LEAVES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  output logic             ready,
  input  logic             func,
  input  logic [IDX_W-1:0] index_a,
  input  logic [IDX_W-1:0] index_b,
  input  logic [VAL_W-1:0] value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] product
);

  localparam int unsigned NODES = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(NODES);
  localparam int unsigned PW    = AW + 1;  // holds r up to 2*LEAVES

  // Node memory: one write port and one read port, registered read
  logic [VAL_W-1:0] mem [NODES];
  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [VAL_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  state_t           state, state_next;
  logic [PW-1:0]    l, r;
  logic [PW-1:0]    node;
  logic [VAL_W-1:0] acc;
  logic [VAL_W-1:0] sib;
  logic             rd_phase;  // update: 0 first read, 1 second read; query: 1 after l is taken
  logic             take_r;    // current query multiply uses r side
  logic             mul_start;
  logic             mul_done;
  logic [VAL_W-1:0] mul_x, mul_y, mul_p;
  logic [PW-1:0]    clr;

  rpmt_modmul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .x(mul_x), .y(mul_y),
    .done(mul_done), .prod(mul_p)
  );

  logic [PW-1:0] hi_c;
  logic [VAL_W-1:0] v_red;
  always_comb begin
    hi_c  = ({1'b0, index_b} >= PW'(LEAVES)) ? PW'(LEAVES - 1) : PW'(index_b);
    v_red = (value >= PRODUCT_MOD) ? value - PRODUCT_MOD : value;
  end

  assign ready     = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign product   = acc;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Next state and memory/multiplier control
  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = node[AW-1:0];
    wdata      = mul_p;
    raddr      = node[AW-1:0];
    mul_start  = 1'b0;
    mul_x      = acc;
    mul_y      = rdata;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr[AW-1:0];
        wdata = VAL_W'(1);
        if (clr == PW'(NODES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (valid) begin
          if (func == FUNC_UPDATE) begin
            if ({1'b0, index_a} < PW'(LEAVES)) begin
              we         = 1'b1;
              waddr      = AW'(PW'(index_a) + PW'(LEAVES));
              wdata      = v_red;
              state_next = ST_UPD_RD;
            end
          end else if ({1'b0, index_a} >= PW'(LEAVES) || PW'(index_a) > hi_c) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_Q_STEP;
          end
        end
      end
      ST_UPD_RD: begin
        // read left child then right child of parent node
        raddr = {node[AW-1:1], rd_phase};
        state_next = ST_UPD_WAIT;
      end
      ST_UPD_WAIT: begin
        if (rd_phase) begin
          mul_start  = 1'b1;
          mul_x      = sib;
          mul_y      = rdata;
          state_next = ST_UPD_MUL;
        end else begin
          state_next = ST_UPD_RD;
        end
      end
      ST_UPD_MUL: begin
        if (mul_done) begin
          we    = 1'b1;
          waddr = AW'(node >> 1);
          if ((node >> 1) == PW'(1)) state_next = ST_IDLE;
          else                       state_next = ST_UPD_RD;
        end
      end
      ST_Q_STEP: begin
        if (l >= r) begin
          state_next = ST_OUT;
        end else if (l[0] && !rd_phase) begin
          raddr      = l[AW-1:0];
          state_next = ST_Q_WAIT;
        end else if (r[0]) begin
          raddr      = AW'(r - 1'b1);
          state_next = ST_Q_WAIT;
        end
      end
      ST_Q_WAIT: begin
        mul_start  = 1'b1;
        state_next = ST_Q_MUL;
      end
      ST_Q_MUL: begin
        if (mul_done) state_next = ST_Q_STEP;
      end
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr      <= '0;
      rd_phase <= 1'b0;
      take_r   <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: clr <= clr + 1'b1;
        ST_IDLE: begin
          rd_phase <= 1'b0;
          acc      <= VAL_W'(1);
          node     <= PW'(index_a) + PW'(LEAVES);
          l        <= PW'(index_a) + PW'(LEAVES);
          r        <= hi_c + PW'(LEAVES) + PW'(1);
        end
        ST_UPD_WAIT: begin
          if (!rd_phase) sib <= rdata;
          rd_phase <= ~rd_phase;
        end
        ST_UPD_MUL: if (mul_done) node <= node >> 1;
        ST_Q_STEP: begin
          if (l < r) begin
            if (l[0] && !rd_phase) begin
              take_r <= 1'b0;
            end else if (r[0]) begin
              take_r <= 1'b1;
            end else begin
              l        <= l >> 1;
              r        <= r >> 1;
              rd_phase <= 1'b0;
            end
          end
        end
        ST_Q_MUL: begin
          if (mul_done) begin
            acc <= mul_p;
            if (take_r) begin
              r <= r - 1'b1;
            end else begin
              l        <= l + 1'b1;
              rd_phase <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/rpmt_modmul.sv
// Iterative modular multiplier: one multiplier bit per cycle (shift-add-reduce).
// Depends on rpmt_pkg.
module rpmt_modmul
  import rpmt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] x,
  input  logic [VAL_W-1:0] y,
  output logic             done,
  output logic [VAL_W-1:0] prod
);

  localparam int unsigned CNT_W = $clog2(VAL_W + 1);

  logic [VAL_W-1:0] acc;
  logic [VAL_W-1:0] mcand;
  logic [VAL_W-1:0] mplier;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [VAL_W:0]   dbl;
  logic [VAL_W-1:0] dbl_r;
  logic [VAL_W:0]   add;
  logic [VAL_W-1:0] add_r;

  // acc = 2*acc mod M, then + mcand mod M if the top bit is set
  always_comb begin
    dbl   = {acc, 1'b0};
    dbl_r = (dbl >= {1'b0, PRODUCT_MOD}) ? VAL_W'(dbl - {1'b0, PRODUCT_MOD}) : dbl[VAL_W-1:0];
    add   = {1'b0, dbl_r} + {1'b0, mcand};
    add_r = (add >= {1'b0, PRODUCT_MOD}) ? VAL_W'(add - {1'b0, PRODUCT_MOD}) : add[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= CNT_W'(VAL_W);
        acc    <= '0;
        mcand  <= x;
        mplier <= y;
      end else if (busy) begin
        acc    <= mplier[VAL_W-1] ? add_r : dbl_r;
        mplier <= {mplier[VAL_W-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

FILE: hdl/rpmt_checker.sv
// Port-level checker for the range product tree, bound to the top level.
// Depends on rpmt_pkg.
module rpmt_checker
  import rpmt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             valid,
  input logic             ready,
  input logic             func,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] product
);

  // Result stays below the modulus
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> product < PRODUCT_MOD) else $error("product out of range");

  // Never ready while a result is waiting
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !ready) else $error("ready with pending result");

  // An update beat never produces a result next cycle
  a_upd: assert property (@(posedge clk) disable iff (rst)
    valid && ready && func == FUNC_UPDATE |=> !out_valid) else $error("update result");

  // Held result stays stable
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(product)) else $error("result dropped");

endmodule

bind range_product_mod_tree_core rpmt_checker u_chk (
  .clk(clk), .rst(rst), .valid(valid), .ready(ready), .func(func),
  .out_valid(out_valid), .out_ready(out_ready), .product(product)
);
